[hdl/delayed_gate_generator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the delayed gate generator
// Clocked, reset-qualified implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DELAYED_GATE_GENERATOR_MACROS_SVH
`define DELAYED_GATE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DGG_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DGG_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hdl/dgg_pkg.sv]
// ----------------------------------------------------------------------------
// Delayed gate generator package
// Stage codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dgg_pkg;

    // Fixed field widths
    localparam int LEVEL_W     = 15;
    localparam int LENGTH_W    = 24;
    localparam int PULSE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Sequencer stages
    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_DELAY   = 2'd1,
        ST_GATE    = 2'd2
    } t_stage;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_TICKS     = 3'd0,
        REG_GATE_TICKS      = 3'd1,
        REG_END_PULSE_TICKS = 3'd2,
        REG_LOOP_ENABLED    = 3'd3,
        REG_RESUME_ON_LOAD  = 3'd4,
        REG_RISE_THRESHOLD  = 3'd5,
        REG_FALL_THRESHOLD  = 3'd6
    } t_cfg_reg;

    // Register reset values
    localparam logic [LENGTH_W-1:0] DELAY_TICKS_RST      = 24'd480;
    localparam logic [LENGTH_W-1:0] GATE_TICKS_RST       = 24'd49152;
    localparam logic [PULSE_W-1:0]  END_PULSE_TICKS_RST  = 16'd48;
    localparam logic signed [LEVEL_W-1:0] RISE_THRESH_RST = 15'sd1000;
    localparam logic signed [LEVEL_W-1:0] FALL_THRESH_RST = 15'sd0;

endpackage

`default_nettype wire

[hdl/delayed_gate_generator.sv]
// ----------------------------------------------------------------------------
// Delayed gate generator
// Trigger-to-gate generator with a delay stage, end-of-gate pulse and looping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one sample tick per request with
//   the trigger level in millivolts. Output channel (o_valid / i_stall) gives
//   one result per tick: gate, end pulse and the two stage flags.
//   Configuration writes use i_cfg_valid / o_cfg_ready with a register index
//   and data; ready is always high and writes should only be made while idle.
//   A tick's result is in the output register in the cycle after the tick
//   is accepted. Throughput is one tick per cycle while no stall holds it;
//   the sequencer update is a single compare-and-increment on the stage counter.
//   When the receiver stalls a full output register, o_stall rises and the
//   held result stays put; if the output register is being emptied in the
//   same cycle a new tick is still taken.
//   Reset (synchronous, active low) loads register defaults, stops the
//   sequencer, clears counters and the detector and arms the first-tick
//   trigger. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delayed_gate_generator_macros.svh"

module delayed_gate_generator
    import dgg_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    // sample tick input
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [LEVEL_W-1:0]     i_trigger_level,
    // result output
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_gate_out,
    output logic                               o_end_out,
    output logic                               o_delay_active,
    output logic                               o_gate_active
);

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int LEN_B = (COUNT_BITS < LENGTH_W) ? COUNT_BITS : LENGTH_W;
    localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};

    // Configuration registers
    logic [LENGTH_W-1:0]        r_delay_ticks;
    logic [LENGTH_W-1:0]        r_gate_ticks;
    logic [PULSE_W-1:0]         r_end_pulse_ticks;
    logic                       r_loop_enabled;
    logic                       r_resume_on_load;
    logic signed [LEVEL_W-1:0]  r_rise_thresh;
    logic signed [LEVEL_W-1:0]  r_fall_thresh;

    // Sequencer state
    t_stage                     r_stage, n_stage;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_det, n_det;
    logic                       r_first;
    logic [PULSE_W-1:0]         r_pulse, n_pulse;

    // Result register
    logic                       r_out_valid;
    logic                       r_gate_out, n_gate_out;
    logic                       r_end_out, n_end_out;

    logic                       in_take;
    logic                       trig;
    logic                       complete;
    logic [CNT_W-1:0]           count_inc;
    logic [CNT_W-1:0]           delay_len;
    logic [CNT_W-1:0]           gate_len;
    logic [PULSE_W-1:0]         pulse_base;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign in_take     = i_valid && !o_stall;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks     <= DELAY_TICKS_RST;
            r_gate_ticks      <= GATE_TICKS_RST;
            r_end_pulse_ticks <= END_PULSE_TICKS_RST;
            r_loop_enabled    <= 1'b0;
            r_resume_on_load  <= 1'b0;
            r_rise_thresh     <= RISE_THRESH_RST;
            r_fall_thresh     <= FALL_THRESH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DELAY_TICKS:     r_delay_ticks     <= i_cfg_data[LENGTH_W-1:0];
                REG_GATE_TICKS:      r_gate_ticks      <= i_cfg_data[LENGTH_W-1:0];
                REG_END_PULSE_TICKS: r_end_pulse_ticks <= i_cfg_data[PULSE_W-1:0];
                REG_LOOP_ENABLED:    r_loop_enabled    <= i_cfg_data[0];
                REG_RESUME_ON_LOAD:  r_resume_on_load  <= i_cfg_data[0];
                REG_RISE_THRESHOLD:  r_rise_thresh     <= i_cfg_data[LEVEL_W-1:0];
                REG_FALL_THRESHOLD:  r_fall_thresh     <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage lengths taken in the low min(COUNT_BITS, LENGTH_W) bits
    assign delay_len = CNT_W'(r_delay_ticks[LEN_B-1:0]);
    assign gate_len  = CNT_W'(r_gate_ticks[LEN_B-1:0]);

    // Saturating stage count
    assign count_inc = (r_count == CNT_CAP) ? r_count : r_count + 1'b1;

    // Detector, next stage and result for this tick
    always_comb begin
        n_det      = r_det;
        trig       = 1'b0;
        n_stage    = r_stage;
        n_count    = r_count;
        complete   = 1'b0;
        n_gate_out = 1'b0;

        // Schmitt detector with its rising edge as trigger
        if (r_det) begin
            if (i_trigger_level <= r_fall_thresh) begin
                n_det = 1'b0;
            end
        end else if (i_trigger_level >= r_rise_thresh) begin
            n_det = 1'b1;
            trig  = 1'b1;
        end

        if (trig || (r_first && r_resume_on_load && r_loop_enabled)) begin
            n_stage = ST_DELAY;
            n_count = '0;
        end else begin
            case (r_stage)
                ST_DELAY: begin
                    n_count = count_inc;
                    if (count_inc > delay_len) begin
                        n_stage = ST_GATE;
                        n_count = '0;
                    end
                end
                ST_GATE: begin
                    n_count = count_inc;
                    if (count_inc > gate_len) begin
                        complete = 1'b1;
                        n_count  = '0;
                        n_stage  = (r_loop_enabled || n_det) ? ST_DELAY : ST_STOPPED;
                    end else begin
                        n_gate_out = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // End pulse: stretch to the configured length on gate end
        pulse_base = (complete && (r_end_pulse_ticks > r_pulse)) ? r_end_pulse_ticks
                                                                 : r_pulse;
        n_end_out  = (pulse_base != '0);
        n_pulse    = n_end_out ? pulse_base - 1'b1 : pulse_base;
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_STOPPED;
            r_count <= '0;
            r_det   <= 1'b0;
            r_first <= 1'b1;
            r_pulse <= '0;
        end else if (in_take) begin
            r_stage <= n_stage;
            r_count <= n_count;
            r_det   <= n_det;
            r_first <= 1'b0;
            r_pulse <= n_pulse;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; stage flags come from the updated stage register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_gate_out <= n_gate_out;
            r_end_out  <= n_end_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_gate_out     = r_gate_out;
    assign o_end_out      = r_end_out;
    assign o_delay_active = (r_stage == ST_DELAY);
    assign o_gate_active  = (r_stage == ST_GATE);

    // Checks
    `DGG_ASSERT_NOW(a_gate_in_stage, i_clk, i_rst_n, o_valid && o_gate_out, o_gate_active, "gate high outside gate stage")
    `DGG_ASSERT_NOW(a_stopped_count, i_clk, i_rst_n, r_stage == ST_STOPPED, r_count == '0, "stage count not clear while stopped")
    `DGG_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, in_take, o_valid, "accepted tick gave no result")

endmodule

`default_nettype wire

[verif/delayed_gate_generator_tb.sv]
// ----------------------------------------------------------------------------
// Delayed gate generator testbench
// Sends sample ticks with trigger levels through the valid/stall request
// channel and checks every tick result against a cycle-free sequencer model
// kept alongside. Directed tests cover the first-tick trigger, zero stage
// lengths, held and crossed thresholds; random phases (the first at maximum
// lengths) reprogram the registers between trigger bursts, both sides idling.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_gate_generator_tb;
    import dgg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_CYCLES = 120;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LEVEL_MIN   = -16000;
    localparam int LEVEL_MAX   = 16000;

    typedef struct packed {
        logic gate_out;
        logic end_out;
        logic delay_active;
        logic gate_active;
    } t_tick_outputs;

    // DUT connections
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [LEVEL_W-1:0] i_trigger_level = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_gate_out;
    logic                      o_end_out;
    logic                      o_delay_active;
    logic                      o_gate_active;

    // Sequencer model: registers
    logic [LENGTH_W-1:0]        cfg_delay = DELAY_TICKS_RST;
    logic [LENGTH_W-1:0]        cfg_gate = GATE_TICKS_RST;
    logic [PULSE_W-1:0]         cfg_end_pulse = END_PULSE_TICKS_RST;
    logic                       cfg_loop = 1'b0;
    logic                       cfg_resume = 1'b0;
    logic signed [LEVEL_W-1:0]  cfg_rise = RISE_THRESH_RST;
    logic signed [LEVEL_W-1:0]  cfg_fall = FALL_THRESH_RST;

    // Sequencer model: state
    t_stage               seq_stage = ST_STOPPED;
    logic [LENGTH_W:0]    seq_count = '0;
    logic                 det_high = 1'b0;
    logic                 first_pending = 1'b1;
    logic [PULSE_W-1:0]   pulse_left = '0;

    t_tick_outputs expected_ticks[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    bit            steady_tx = 1'b0;
    bit            steady_rx = 1'b0;
    bit            hold_req = 1'b0;
    int            hold_left = 0;

    delayed_gate_generator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_trigger_level (i_trigger_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_gate_out      (o_gate_out),
        .o_end_out       (o_end_out),
        .o_delay_active  (o_delay_active),
        .o_gate_active   (o_gate_active)
    );

    always #10 i_clk = ~i_clk;

    // One sample tick through the sequencer model
    function automatic t_tick_outputs advance_sequencer(input logic signed [LEVEL_W-1:0] level);
        logic          fired;
        logic          gate_on;
        logic          finished;
        t_tick_outputs r;
        fired    = 1'b0;
        gate_on  = 1'b0;
        finished = 1'b0;

        // Schmitt detector
        if (det_high) begin
            if (level <= cfg_fall)
                det_high = 1'b0;
        end else if (level >= cfg_rise) begin
            det_high = 1'b1;
            fired    = 1'b1;
        end

        // Stage sequencing; a trigger wins over any advance
        if (fired || (first_pending && cfg_resume && cfg_loop)) begin
            seq_stage = ST_DELAY;
            seq_count = '0;
        end else if (seq_stage == ST_DELAY) begin
            if (seq_count != '1)
                seq_count++;
            if (seq_count > {1'b0, cfg_delay}) begin
                seq_stage = ST_GATE;
                seq_count = '0;
            end
        end else if (seq_stage == ST_GATE) begin
            if (seq_count != '1)
                seq_count++;
            if (seq_count > {1'b0, cfg_gate}) begin
                finished  = 1'b1;
                seq_count = '0;
                seq_stage = (cfg_loop || det_high) ? ST_DELAY : ST_STOPPED;
            end else begin
                gate_on = 1'b1;
            end
        end

        // End-of-gate pulse, stretched rather than restarted
        if (finished && cfg_end_pulse > pulse_left)
            pulse_left = cfg_end_pulse;
        r.end_out = (pulse_left != '0);
        if (r.end_out)
            pulse_left--;

        first_pending  = 1'b0;
        r.gate_out     = gate_on;
        r.delay_active = (seq_stage == ST_DELAY);
        r.gate_active  = (seq_stage == ST_GATE);
        return r;
    endfunction

    // Random level in [lo, hi]; anywhere in range if the window is empty
    function automatic logic [LEVEL_W-1:0] rand_level(input int lo, input int hi);
        int v;
        if (hi < lo)
            v = int'($urandom_range(LEVEL_MAX - LEVEL_MIN)) + LEVEL_MIN;
        else
            v = lo + int'($urandom_range(hi - lo));
        return v[LEVEL_W-1:0];
    endfunction

    // Mostly short stage lengths, with zero and the top value now and then
    function automatic logic [LENGTH_W-1:0] pick_length(input int unsigned short_max,
                                                        input logic [LENGTH_W-1:0] top);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 14)
            return top;
        return LENGTH_W'($urandom_range(short_max));
    endfunction

    // Config write request; model follows on acceptance
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_DELAY_TICKS:     cfg_delay     = data[LENGTH_W-1:0];
            REG_GATE_TICKS:      cfg_gate      = data[LENGTH_W-1:0];
            REG_END_PULSE_TICKS: cfg_end_pulse = data[PULSE_W-1:0];
            REG_LOOP_ENABLED:    cfg_loop      = data[0];
            REG_RESUME_ON_LOAD:  cfg_resume    = data[0];
            REG_RISE_THRESHOLD:  cfg_rise      = data[LEVEL_W-1:0];
            REG_FALL_THRESHOLD:  cfg_fall      = data[LEVEL_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One tick request; each cycle in front idles with the idle chance
    task automatic send_tick(input logic [LEVEL_W-1:0] level);
        if (!steady_tx) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_trigger_level <= level;
        do @(posedge i_clk); while (o_stall);
        expected_ticks.push_back(advance_sequencer(level));
    endtask

    // Sender stops and waits for every outstanding result
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_ticks.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Trigger patterns: held highs, lows with the odd band level, and noise
    task automatic run_trigger_bursts(input int count);
        int sent;
        int span;
        int hi_len;
        int lo_len;
        int k;
        sent = 0;
        while (sent < count) begin
            span = int'(cfg_delay) + int'(cfg_gate) + 2;
            if (span > 16)
                span = 16;
            if ($urandom_range(99) < 75) begin
                hi_len = $urandom_range(1, span);
                lo_len = $urandom_range(1, 2 * span + 4);
                for (k = 0; k < hi_len; k++)
                    send_tick(rand_level(cfg_rise, LEVEL_MAX));
                for (k = 0; k < lo_len; k++) begin
                    if ($urandom_range(9) == 0)
                        send_tick(rand_level(int'(cfg_fall) + 1, int'(cfg_rise) - 1));
                    else
                        send_tick(rand_level(LEVEL_MIN, cfg_fall));
                end
                sent += hi_len + lo_len;
            end else begin
                hi_len = $urandom_range(1, 8);
                for (k = 0; k < hi_len; k++)
                    send_tick(rand_level(LEVEL_MIN, LEVEL_MAX));
                sent += hi_len;
            end
        end
    endtask

    // Reprogram every register; forced top lengths when asked
    task automatic program_random_setting(input bit top_lengths);
        int rise;
        int fall;
        int t;
        rise = int'($urandom_range(12000)) - 4000;
        fall = rise - int'($urandom_range(4000));
        if ($urandom_range(99) < 15) begin
            t    = rise;
            rise = fall;
            fall = t;
        end
        if ($urandom_range(99) < 10)
            rise = LEVEL_MAX;
        if ($urandom_range(99) < 10)
            fall = LEVEL_MIN;
        if (fall < LEVEL_MIN)
            fall = LEVEL_MIN;
        if (top_lengths) begin
            write_reg(REG_DELAY_TICKS, '1);
            write_reg(REG_GATE_TICKS, '1);
            write_reg(REG_END_PULSE_TICKS, 24'hFFFF);
        end else begin
            write_reg(REG_DELAY_TICKS, pick_length(10, '1));
            write_reg(REG_GATE_TICKS, pick_length(10, '1));
            write_reg(REG_END_PULSE_TICKS, 24'(pick_length(8, 24'hFFFF)));
        end
        write_reg(REG_LOOP_ENABLED, 24'($urandom_range(1)));
        write_reg(REG_RESUME_ON_LOAD, 24'($urandom_range(1)));
        write_reg(REG_RISE_THRESHOLD, 24'(rise));
        write_reg(REG_FALL_THRESHOLD, 24'(fall));
    endtask

    // First tick after reset fires with loop and resume set; then loops
    task automatic test_first_tick_loop();
        int k;
        write_reg(REG_LOOP_ENABLED, 24'd1);
        write_reg(REG_RESUME_ON_LOAD, 24'd1);
        write_reg(REG_DELAY_TICKS, 24'd2);
        write_reg(REG_GATE_TICKS, 24'd3);
        write_reg(REG_END_PULSE_TICKS, 24'd2);
        for (k = 0; k < 10; k++)
            send_tick('0);
        send_tick(LEVEL_W'(LEVEL_MIN));
        send_tick(LEVEL_W'(LEVEL_MAX));
        send_tick(LEVEL_W'(LEVEL_MIN));
        wait_results_drained();
    endtask

    // Zero lengths, no pulse, held trigger retrigger, crossed thresholds
    task automatic test_zero_lengths_crossed();
        int k;
        write_reg(REG_DELAY_TICKS, '0);
        write_reg(REG_GATE_TICKS, '0);
        write_reg(REG_END_PULSE_TICKS, '0);
        write_reg(REG_LOOP_ENABLED, '0);
        write_reg(REG_RESUME_ON_LOAD, '0);
        write_reg(REG_RISE_THRESHOLD, 24'(LEVEL_MAX));
        write_reg(REG_FALL_THRESHOLD, 24'(LEVEL_MIN));
        // unused index must be ignored
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        for (k = 0; k < 4; k++)
            send_tick(LEVEL_W'(LEVEL_MAX));
        send_tick(LEVEL_W'(LEVEL_MIN));
        send_tick('0);
        send_tick('0);
        wait_results_drained();
        write_reg(REG_RISE_THRESHOLD, 24'(-100));
        write_reg(REG_FALL_THRESHOLD, 24'(100));
        write_reg(REG_END_PULSE_TICKS, 24'd1);
        send_tick(LEVEL_W'(-100));
        send_tick(LEVEL_W'(100));
        send_tick('0);
        send_tick(LEVEL_W'(200));
        send_tick(LEVEL_W'(LEVEL_MIN));
        wait_results_drained();
    endtask

    // Random settings, each followed by a burst of trigger patterns
    task automatic test_random_settings();
        int p;
        for (p = 0; p < 8; p++) begin
            program_random_setting(p == 0);
            steady_tx = (p == 3);
            steady_rx = (p == 3);
            run_trigger_bursts(200);
            wait_results_drained();
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    // Receiver holds off while ticks keep coming, so the input stalls
    task automatic test_receiver_hold();
        program_random_setting(1'b0);
        steady_tx = 1'b1;
        hold_req  = 1'b1;
        run_trigger_bursts(150);
        wait_results_drained();
        steady_tx = 1'b0;
    endtask

    // Sender pauses mid-stream until every result is back
    task automatic test_sender_pause();
        program_random_setting(1'b0);
        run_trigger_bursts(50);
        wait_results_drained();
        run_trigger_bursts(50);
        wait_results_drained();
    endtask

    // Receiver stall: random, steady, or a long counted hold
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (steady_rx) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker: oldest expectation first
    always @(posedge i_clk) begin
        t_tick_outputs want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_ticks.size() == 0) begin
                $error("result with no tick outstanding");
                fail_count++;
            end else begin
                want = expected_ticks.pop_front();
                if (o_gate_out !== want.gate_out) begin
                    $error("gate_out: expected %0b, got %0b", want.gate_out, o_gate_out);
                    fail_count++;
                end
                if (o_end_out !== want.end_out) begin
                    $error("end_out: expected %0b, got %0b", want.end_out, o_end_out);
                    fail_count++;
                end
                if (o_delay_active !== want.delay_active) begin
                    $error("delay_active: expected %0b, got %0b", want.delay_active,
                           o_delay_active);
                    fail_count++;
                end
                if (o_gate_active !== want.gate_active) begin
                    $error("gate_active: expected %0b, got %0b", want.gate_active,
                           o_gate_active);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("delayed_gate_generator_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_tick_loop();
        test_zero_lengths_crossed();
        test_random_settings();
        test_receiver_hold();
        test_sender_pause();

        repeat (10) @(posedge i_clk);
        if (expected_ticks.size() != 0) begin
            $error("%0d tick results never arrived", expected_ticks.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("delayed_gate_generator_tb: clean");
        else
            $display("delayed_gate_generator_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
